// ----- rtl/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/mbcw_pkg.sv -----
`default_nettype none

package mbcw_pkg;

   localparam int unsigned FRAME_LEN = 8;
   localparam int unsigned CRC_BYTES = 6;
   localparam int unsigned CNT_W     = 4;
   localparam int unsigned IDX_W     = 3;

   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [7:0]  FUNC_WRITE_COIL = 8'h05;
   localparam logic [7:0]  ADDR_RESET      = 8'h01;

   typedef logic [7:0] byte_type;

endpackage

`default_nettype wire

// ----- rtl/mbcw_crc_byte.sv -----
`default_nettype none

// reflected crc-16 update over one byte, lsb first
module mbcw_crc_byte (
   input  wire  logic [15:0]           crc_cur,
   input  wire  mbcw_pkg::byte_type    data_byte,
   output logic [15:0]                 crc_next
);

   logic [15:0] acc;

   always_comb begin
      acc = crc_cur ^ {8'h00, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = {1'b0, acc[15:1]} ^ mbcw_pkg::CRC_POLY;
         end else begin
            acc = {1'b0, acc[15:1]};
         end
      end
      crc_next = acc;
   end

endmodule

`default_nettype wire

// ----- rtl/modbus_rtu_coil_write_slave.sv -----
// latency: a matching frame's first response item is valid the cycle after its last byte
// throughput: one request byte per cycle bar the stall below, one rsp item per ready cycle
// a frame-end byte stalls only while the previous 8-item response is still draining
// reset (synchronous, active high) clears byte count and response state, sets the crc
// to its initial value and sets the station address to 1
`default_nettype none
`include "assert_macros.svh"

module modbus_rtu_coil_write_slave (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   input  wire  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire  logic        req_tlast,   // frame_end
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] tx_byte
   output logic              rsp_tlast,   // last
   output logic [5:0]        rsp_tuser,   // [0] relay_write, [4:1] relay_index, [5] relay_level
   input  wire  logic        csr_valid,
   output logic              csr_ready,
   input  wire  logic [7:0]  csr_data    // [7:0] slave_address
);

   localparam int unsigned FL = mbcw_pkg::FRAME_LEN;

   mbcw_pkg::byte_type                 store_ff [FL];
   mbcw_pkg::byte_type                 shift_ff [FL];
   mbcw_pkg::byte_type                 shift_in [FL];
   logic [mbcw_pkg::CNT_W-1:0]         byte_count_ff, byte_count_in;
   logic [15:0]                        crc_ff, crc_in, crc_upd;
   logic [7:0]                         addr_ff;
   logic                               busy_ff, busy_in;
   logic [mbcw_pkg::IDX_W-1:0]         tx_cnt_ff, tx_cnt_in;
   logic [3:0]                         index_ff, index_in;
   logic                               level_ff, level_in;

   logic       req_acc, rsp_done, frame_ok, load, first;
   logic [7:0] b7;

   mbcw_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (req_tdata),
      .crc_next  (crc_upd)
   );

   assign csr_ready = 1'b1;
   assign rsp_done  = busy_ff && rsp_tready && (tx_cnt_ff == mbcw_pkg::IDX_W'(FL - 1));
   assign req_tready = !busy_ff || !req_tlast || rsp_done;
   assign req_acc    = req_tvalid && req_tready;

   // byte 7 may be the byte arriving right now
   assign b7 = (byte_count_ff == mbcw_pkg::CNT_W'(FL - 1)) ? req_tdata : store_ff[FL-1];

   assign frame_ok = (byte_count_ff >= mbcw_pkg::CNT_W'(FL - 1))
                  && ({b7, store_ff[FL-2]} == crc_ff)
                  && (store_ff[0] == addr_ff)
                  && (store_ff[1] == mbcw_pkg::FUNC_WRITE_COIL);

   assign load  = req_acc && req_tlast && frame_ok;
   assign first = (tx_cnt_ff == '0);

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = shift_ff[0];
   assign rsp_tlast  = (tx_cnt_ff == mbcw_pkg::IDX_W'(FL - 1));
   assign rsp_tuser  = {level_ff & first, index_ff & {4{first}}, first};

   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      if (req_acc) begin
         if (byte_count_ff < mbcw_pkg::CNT_W'(FL)) begin
            byte_count_in = byte_count_ff + 1'b1;
            if (byte_count_ff < mbcw_pkg::CNT_W'(mbcw_pkg::CRC_BYTES)) begin
               crc_in = crc_upd;
            end
         end
         if (req_tlast) begin
            byte_count_in = '0;
            crc_in        = mbcw_pkg::CRC_INIT;
         end
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      tx_cnt_in = tx_cnt_ff;
      index_in  = index_ff;
      level_in  = level_ff;
      for (int i = 0; i < FL; i++) begin
         shift_in[i] = shift_ff[i];
      end
      if (busy_ff && rsp_tready) begin
         tx_cnt_in = tx_cnt_ff + 1'b1;
         for (int i = 0; i < FL - 1; i++) begin
            shift_in[i] = shift_ff[i+1];
         end
         if (rsp_done) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in   = 1'b1;
         tx_cnt_in = '0;
         index_in  = store_ff[3][3:0];
         level_in  = |{store_ff[4], store_ff[5]};
         for (int i = 0; i < FL - 1; i++) begin
            shift_in[i] = store_ff[i];
         end
         shift_in[FL-1] = b7;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         crc_ff        <= mbcw_pkg::CRC_INIT;
         addr_ff       <= mbcw_pkg::ADDR_RESET;
         busy_ff       <= 1'b0;
         tx_cnt_ff     <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         busy_ff       <= busy_in;
         tx_cnt_ff     <= tx_cnt_in;
         if (csr_valid && csr_ready) begin
            addr_ff <= csr_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      index_ff <= index_in;
      level_ff <= level_in;
      for (int i = 0; i < FL; i++) begin
         shift_ff[i] <= shift_in[i];
      end
      if (req_acc && (byte_count_ff < mbcw_pkg::CNT_W'(FL))) begin
         store_ff[byte_count_ff[mbcw_pkg::IDX_W-1:0]] <= req_tdata;
      end
   end

   `ASSERT_IMPLIES(a_no_overrun, clock, reset, load, (!busy_ff || rsp_done))
   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, (byte_count_ff <= mbcw_pkg::CNT_W'(FL)))
   `ASSERT_NEXT(a_frame_close, clock, reset, (req_acc && req_tlast), ((byte_count_ff == '0) && (crc_ff == mbcw_pkg::CRC_INIT)))
   `ASSERT_NEXT(a_drain_idle, clock, reset, (rsp_done && !load), !busy_ff)

endmodule

`default_nettype wire

// ----- dv/tb_modbus_rtu_coil_write_slave.sv -----
`default_nettype none

module tb_modbus_rtu_coil_write_slave;
   timeunit 1ns;
   timeprecision 1ps;

   typedef mbcw_pkg::byte_type byte_q_type[$];

   typedef struct {
      mbcw_pkg::byte_type tx_byte;
      logic               last;
      logic               relay_write;
      logic [3:0]         relay_index;
      logic               relay_level;
   } coil_echo_type;

   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_CRC,
      FRAME_BAD_ADDR,
      FRAME_BAD_FUNC,
      FRAME_SHORT,
      FRAME_LONG,
      FRAME_NOISE
   } frame_kind_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [5:0] rsp_tuser;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data   = '0;

   // slave-side predictor state
   mbcw_pkg::byte_type         rx_frame [mbcw_pkg::FRAME_LEN];
   logic [15:0]                rx_crc       = mbcw_pkg::CRC_INIT;
   logic [mbcw_pkg::CNT_W-1:0] rx_count     = '0;
   mbcw_pkg::byte_type         station_addr = mbcw_pkg::ADDR_RESET;

   coil_echo_type coil_echo_q[$];
   int            mismatch_count = 0;
   int            send_idle_pct  = 0;
   int            recv_idle_pct  = 0;
   int            hold_cycles    = 0;
   int            items_sent     = 0;

   modbus_rtu_coil_write_slave dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                              input mbcw_pkg::byte_type b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ mbcw_pkg::CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t mismatch: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic predict_rx_byte(input mbcw_pkg::byte_type b, input logic fe);
      coil_echo_type e;
      logic [15:0]   crc_rx;
      if (rx_count < mbcw_pkg::FRAME_LEN) begin
         rx_frame[rx_count[mbcw_pkg::IDX_W-1:0]] = b;
         if (rx_count < mbcw_pkg::CRC_BYTES) rx_crc = crc16_step(rx_crc, b);
         rx_count++;
      end
      if (fe) begin
         crc_rx = {rx_frame[7], rx_frame[6]};
         if (rx_count >= mbcw_pkg::FRAME_LEN && crc_rx == rx_crc
             && rx_frame[0] == station_addr
             && rx_frame[1] == mbcw_pkg::FUNC_WRITE_COIL) begin
            for (int k = 0; k < mbcw_pkg::FRAME_LEN; k++) begin
               e.tx_byte     = rx_frame[k];
               e.last        = (k == mbcw_pkg::FRAME_LEN - 1);
               e.relay_write = (k == 0);
               e.relay_index = (k == 0) ? rx_frame[3][3:0] : 4'd0;
               e.relay_level = (k == 0) ? ((rx_frame[4] | rx_frame[5]) != 8'h00) : 1'b0;
               coil_echo_q.push_back(e);
            end
         end
         rx_count = '0;
         rx_crc   = mbcw_pkg::CRC_INIT;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) predict_rx_byte(req_tdata, req_tlast);
   end

   always @(posedge clock) begin : check_rsp
      coil_echo_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (coil_echo_q.size() == 0) begin
            report_mismatch("response item with none expected", 16'(rsp_tdata), 16'h0000);
         end else begin
            want = coil_echo_q.pop_front();
            if (rsp_tdata !== want.tx_byte)
               report_mismatch("tx_byte", 16'(rsp_tdata), 16'(want.tx_byte));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 16'(rsp_tlast), 16'(want.last));
            if (rsp_tuser[0] !== want.relay_write)
               report_mismatch("relay_write", 16'(rsp_tuser[0]), 16'(want.relay_write));
            if (rsp_tuser[4:1] !== want.relay_index)
               report_mismatch("relay_index", 16'(rsp_tuser[4:1]), 16'(want.relay_index));
            if (rsp_tuser[5] !== want.relay_level)
               report_mismatch("relay_level", 16'(rsp_tuser[5]), 16'(want.relay_level));
         end
      end
   end

   // receiver: random stalls, or a counted hold-off when one is requested
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input mbcw_pkg::byte_type b, input logic fe);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fe;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_frame(input byte_q_type f, input logic noisy_ends);
      logic fe;
      for (int i = 0; i < f.size(); i++) begin
         fe = (i == f.size() - 1) || (noisy_ends && $urandom_range(3) == 0);
         send_byte(f[i], fe);
      end
      items_sent += f.size();
   endtask

   function automatic byte_q_type coil_request(input mbcw_pkg::byte_type addr,
                                               input mbcw_pkg::byte_type func,
                                               input logic [15:0] coil_reg,
                                               input logic [15:0] coil_val);
      byte_q_type  f;
      logic [15:0] crc;
      f.push_back(addr);
      f.push_back(func);
      f.push_back(coil_reg[15:8]);
      f.push_back(coil_reg[7:0]);
      f.push_back(coil_val[15:8]);
      f.push_back(coil_val[7:0]);
      crc = mbcw_pkg::CRC_INIT;
      foreach (f[i]) crc = crc16_step(crc, f[i]);
      f.push_back(crc[7:0]);
      f.push_back(crc[15:8]);
      return f;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      // let the predictor see the last accepted byte first
      @(posedge clock);
      while (coil_echo_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_station_addr(input mbcw_pkg::byte_type a);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= a;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      station_addr = a;
   endtask

   task automatic send_request(input frame_kind_type kind);
      byte_q_type         f;
      mbcw_pkg::byte_type addr;
      mbcw_pkg::byte_type func;
      logic [15:0]        coil_val;
      int                 n;
      addr = station_addr;
      func = mbcw_pkg::FUNC_WRITE_COIL;
      if (kind == FRAME_BAD_ADDR)
         addr = station_addr ^ mbcw_pkg::byte_type'($urandom_range(1, 255));
      if (kind == FRAME_BAD_FUNC)
         func = mbcw_pkg::FUNC_WRITE_COIL ^ mbcw_pkg::byte_type'($urandom_range(1, 255));
      case ($urandom_range(3))
         0: coil_val = 16'h0000;
         1: coil_val = 16'hFF00;
         default: coil_val = 16'($urandom_range(16'hFFFF));
      endcase
      f = coil_request(addr, func, 16'($urandom_range(16'hFFFF)), coil_val);
      case (kind)
         FRAME_BAD_CRC:
            f[6 + $urandom_range(1)] ^= mbcw_pkg::byte_type'(1 << $urandom_range(7));
         FRAME_SHORT: begin
            n = $urandom_range(1, mbcw_pkg::FRAME_LEN - 1);
            while (f.size() > n) void'(f.pop_back());
         end
         FRAME_LONG: repeat ($urandom_range(1, 6))
            f.push_back(mbcw_pkg::byte_type'($urandom_range(255)));
         FRAME_NOISE: begin
            f = {};
            repeat ($urandom_range(1, 12))
               f.push_back(mbcw_pkg::byte_type'($urandom_range(255)));
         end
         default: ;
      endcase
      send_frame(f, kind == FRAME_NOISE);
   endtask

   function automatic frame_kind_type pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 60) return FRAME_GOOD;
      if (r < 68) return FRAME_BAD_CRC;
      if (r < 76) return FRAME_BAD_ADDR;
      if (r < 84) return FRAME_BAD_FUNC;
      if (r < 90) return FRAME_SHORT;
      if (r < 95) return FRAME_LONG;
      return FRAME_NOISE;
   endfunction

   // relay 15 with the upper register bits set, coil on
   task automatic test_reset_address_echo();
      send_frame(coil_request(mbcw_pkg::ADDR_RESET, mbcw_pkg::FUNC_WRITE_COIL,
                              16'hABFF, 16'hFF00), 1'b0);
   endtask

   // ninth byte must be ignored, relay 0 with coil off
   task automatic test_long_frame();
      byte_q_type f;
      f = coil_request(mbcw_pkg::ADDR_RESET, mbcw_pkg::FUNC_WRITE_COIL, 16'h0010, 16'h0000);
      f.push_back(8'hFF);
      send_frame(f, 1'b0);
   endtask

   // seven bytes, then a lone byte closing a frame: neither answers
   task automatic test_short_frames();
      byte_q_type f;
      f = coil_request(mbcw_pkg::ADDR_RESET, mbcw_pkg::FUNC_WRITE_COIL, 16'h0003, 16'h0001);
      void'(f.pop_back());
      send_frame(f, 1'b0);
      f = {8'h00};
      send_frame(f, 1'b0);
   endtask

   task automatic test_address_extremes();
      write_station_addr(8'h00);
      repeat (3) send_request(pick_kind());
      write_station_addr(8'hFF);
      repeat (3) send_request(pick_kind());
   endtask

   task automatic test_random_traffic();
      int send_pct[3] = '{30, 61, 0};
      int recv_pct[3] = '{61, 30, 0};
      for (int p = 0; p < 3; p++) begin
         write_station_addr(mbcw_pkg::byte_type'($urandom_range(255)));
         send_idle_pct = send_pct[p];
         recv_idle_pct = recv_pct[p];
         items_sent = 0;
         while (items_sent < 50) send_request(pick_kind());
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_station_addr(8'h5A);
      hold_cycles = 60;
      repeat (4) send_request(FRAME_GOOD);
      // sender pause until all echoes are out
      wait_drained();
      repeat (2) send_request(FRAME_GOOD);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_address_echo();
      test_long_frame();
      test_short_frames();
      test_address_extremes();
      test_random_traffic();
      test_backpressure();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("** modbus_rtu_coil_write_slave: PASSED **");
      end else begin
         $display("** modbus_rtu_coil_write_slave: FAILED **");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("** modbus_rtu_coil_write_slave: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
